// ===== hw/rtl/sorted_max_priority_queue_defines.svh =====
// Assertion macros for the sorted max priority queue.
`ifndef SORTED_MAX_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_MAX_PRIORITY_QUEUE_DEFINES_SVH

// Clocked implication check, disabled in reset.
`define SMPQ_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Clocked next-cycle implication check, disabled in reset.
`define SMPQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/smpq_pkg.sv =====
// ----------------------------------------------------------------------------
// smpq_pkg
// Shared constants and types for the sorted max priority queue.
// ----------------------------------------------------------------------------
package smpq_pkg;

  localparam int DEPTH_DEF       = 16;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int IO_WIDTH        = 32;
  localparam int COUNT_FIELD_W   = 5;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic    [IO_WIDTH-1:0]      out_value;
    status_t                     status;
    logic                        now_empty;
    logic    [COUNT_FIELD_W-1:0] entry_count;
  } result_t;

endpackage

// ===== hw/rtl/smpq_if.sv =====
// ----------------------------------------------------------------------------
// smpq_cmd_if / smpq_res_if
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
interface smpq_cmd_if;
  logic                           valid;
  logic                           ready;
  logic                           cmd;
  logic signed [smpq_pkg::IO_WIDTH-1:0] value;
  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface smpq_res_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [smpq_pkg::IO_WIDTH-1:0]      out_value;
  logic [1:0]                                status;
  logic                                      now_empty;
  logic [smpq_pkg::COUNT_FIELD_W-1:0]        entry_count;
  modport source (output valid, output out_value, output status, output now_empty,
                  output entry_count, input ready);
  modport sink   (input valid, input out_value, input status, input now_empty,
                  input entry_count, output ready);
endinterface

// ===== hw/rtl/smpq_ram.sv =====
// ----------------------------------------------------------------------------
// smpq_ram
// Single-port-write, single-port-read entry memory, registered read data.
// ----------------------------------------------------------------------------
module smpq_ram #(
  parameter int DEPTH       = smpq_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = smpq_pkg::VALUE_WIDTH_DEF,
  localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [AW-1:0]          waddr,
  input  logic [VALUE_WIDTH-1:0] wdata,
  input  logic [AW-1:0]          raddr,
  output logic [VALUE_WIDTH-1:0] rdata
);
  logic [VALUE_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/smpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// smpq_ctrl
// Sequencer: walks the sorted memory slot by slot, reading then writing, to shift entries.
// ----------------------------------------------------------------------------
module smpq_ctrl #(
  parameter int DEPTH       = smpq_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = smpq_pkg::VALUE_WIDTH_DEF,
  localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW         = $clog2(DEPTH + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  smpq_cmd_if.sink               in_ch,
  smpq_res_if.source             out_ch,
  output logic                   mem_we,
  output logic [AW-1:0]          mem_waddr,
  output logic [VALUE_WIDTH-1:0] mem_wdata,
  output logic [AW-1:0]          mem_raddr,
  input  logic [VALUE_WIDTH-1:0] mem_rdata,
  output logic [CW-1:0]          count_o
);
  typedef enum logic [2:0] {
    S_IDLE, S_INS_RD, S_INS_WR, S_REM_RD, S_REM_WR, S_OUT
  } state_t;

  state_t                 state;
  logic [CW-1:0]          count;
  logic [CW-1:0]          idx;       // slot being handled
  logic [VALUE_WIDTH-1:0] val;       // insert key
  logic [VALUE_WIDTH-1:0] head;      // removed top entry
  smpq_pkg::result_t      res;

  logic [VALUE_WIDTH-1:0] in_val;
  logic                   in_fire;
  logic                   out_fire;

  assign in_val   = VALUE_WIDTH'({{(VALUE_WIDTH){in_ch.value[smpq_pkg::IO_WIDTH-1]}},
                                  in_ch.value});
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;

  assign in_ch.ready        = (state == S_IDLE);
  assign out_ch.valid       = (state == S_OUT);
  assign out_ch.out_value   = res.out_value;
  assign out_ch.status      = res.status;
  assign out_ch.now_empty   = res.now_empty;
  assign out_ch.entry_count = res.entry_count;
  assign count_o            = count;

  function automatic logic [smpq_pkg::IO_WIDTH-1:0] widen(input logic [VALUE_WIDTH-1:0] v);
    return smpq_pkg::IO_WIDTH'({{(smpq_pkg::IO_WIDTH){v[VALUE_WIDTH-1]}}, v});
  endfunction

  function automatic smpq_pkg::result_t mk(input logic [smpq_pkg::IO_WIDTH-1:0] ov,
                                           input smpq_pkg::status_t st,
                                           input logic [CW-1:0] c);
    smpq_pkg::result_t r;
    r.out_value   = ov;
    r.status      = st;
    r.now_empty   = (c == '0);
    r.entry_count = smpq_pkg::COUNT_FIELD_W'({{smpq_pkg::COUNT_FIELD_W{1'b0}}, c});
    return r;
  endfunction

  // Memory address and write drive. Insert walks down from the tail, moving
  // slot idx-1 to idx while it is smaller than the key. Remove walks up,
  // moving slot idx-1 to idx-2.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx[AW-1:0];
    mem_wdata = mem_rdata;
    mem_raddr = '0;
    unique case (state)
      S_INS_RD: mem_raddr = AW'(idx - CW'(1));
      S_INS_WR: begin
        mem_we = 1'b1;
        if (idx == '0 || $signed(mem_rdata) >= $signed(val)) begin
          mem_wdata = val;
        end
      end
      S_REM_RD: mem_raddr = AW'(idx - CW'(1));
      S_REM_WR: begin
        mem_we    = (idx != CW'(1));
        mem_waddr = AW'(idx - CW'(2));
      end
      default: ;
    endcase
    if (state == S_IDLE) begin
      mem_raddr = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (in_fire) begin
          if (smpq_pkg::cmd_t'(in_ch.cmd) == smpq_pkg::CMD_INSERT) begin
            val <= in_val;
            idx <= count;
            if (count == CW'(DEPTH)) begin
              res   <= mk('0, smpq_pkg::ST_FULL, count);
              state <= S_OUT;
            end else if (count == '0) begin
              // Empty: write directly at slot zero through the write path.
              state <= S_INS_WR;
            end else begin
              state <= S_INS_RD;
            end
          end else begin
            if (count == '0) begin
              res   <= mk('0, smpq_pkg::ST_EMPTY, count);
              state <= S_OUT;
            end else begin
              idx   <= CW'(1);
              state <= S_REM_WR;  // read of slot 0 issued this cycle
            end
          end
        end
        S_INS_RD: state <= S_INS_WR;
        S_INS_WR: begin
          // Stop once the key is placed (slot zero, or the entry above holds).
          if (idx == '0 || $signed(mem_rdata) >= $signed(val)) begin
            count <= count + CW'(1);
            res   <= mk('0, smpq_pkg::ST_OK, count + CW'(1));
            state <= S_OUT;
          end else begin
            // From slot one, go straight to slot zero; no read is needed there.
            idx   <= idx - CW'(1);
            state <= (idx == CW'(1)) ? S_INS_WR : S_INS_RD;
          end
        end
        S_REM_RD: state <= S_REM_WR;
        S_REM_WR: begin
          if (idx == CW'(1)) begin
            head <= mem_rdata;
          end
          if (idx == count) begin
            count <= count - CW'(1);
            res   <= mk(widen((idx == CW'(1)) ? mem_rdata : head), smpq_pkg::ST_OK,
                        count - CW'(1));
            state <= S_OUT;
          end else begin
            state <= S_REM_RD;
          end
          if (idx != count) begin
            // advance to the next slot
          end
        end
        S_OUT: if (out_fire) begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (state == S_REM_RD) begin
        idx <= idx;
      end
      if (state == S_REM_WR && idx != count) begin
        idx <= idx + CW'(1);
      end
    end
  end
endmodule

// ===== hw/rtl/sorted_max_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_max_priority_queue
// Bounded max priority queue kept in descending order in one memory.
// ----------------------------------------------------------------------------
// Channel | Dir | Word
// in_ch   | in  | cmd, value
// out_ch  | out | out_value, status, now_empty, entry_count
//
// Flow: one word at a time. Insert walks down from the tail, shifting each
// entry smaller than the key down one slot, then writes the key; remove walks
// up through the filled slots, shifting each entry up one slot. Full insert
// and empty remove skip the walk and go straight to the result. The single
// read and write port of the entry memory sets the shift rate. One result
// word follows each command word.
// Reset: rst clears the fill count and the sequencer; memory keeps contents.
// Stalls: the result waits in its register until taken; no new command
// word is taken meanwhile.
`include "sorted_max_priority_queue_defines.svh"

module sorted_max_priority_queue #(
  parameter int DEPTH       = smpq_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = smpq_pkg::VALUE_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst,
  smpq_cmd_if.sink   in_ch,
  smpq_res_if.source out_ch
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [VALUE_WIDTH-1:0] mem_wdata;
  logic [AW-1:0]          mem_raddr;
  logic [VALUE_WIDTH-1:0] mem_rdata;
  logic [CW-1:0]          count;

  // Sequencer: decode commands and walk the sorted array.
  smpq_ctrl #(.DEPTH(DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) u_ctrl (
    .clk, .rst, .in_ch, .out_ch,
    .mem_we, .mem_waddr, .mem_wdata, .mem_raddr, .mem_rdata,
    .count_o(count)
  );

  // Entry storage, largest at slot zero.
  smpq_ram #(.DEPTH(DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) u_ram (
    .clk, .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  // Fill count never exceeds the depth.
  `SMPQ_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, count <= CW'(DEPTH), "count over depth")
  // No command is taken while a result waits.
  `SMPQ_ASSERT_IMP(a_no_overlap, clk, rst, out_ch.valid, !in_ch.ready, "overlap")
  // Count only moves by one.
  `SMPQ_ASSERT_NEXT(a_count_step, clk, rst, 1'b1,
    (count == $past(count)) || (count == $past(count) + CW'(1)) ||
    (count + CW'(1) == $past(count)), "count jump")
endmodule
